@@ hdl/wscfr_pkg.sv @@
// Shared types and codes for the websocket client frame receiver.
package wscfr_pkg;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       local_closing;
	} in_word_t;

	typedef struct packed {
		logic        has_byte;
		logic [7:0]  payload_byte;
		logic        byte_is_control;
		logic [2:0]  event_res;
		logic        message_binary;
		logic [15:0] close_code;
		logic        echo_close;
		logic [3:0]  error_code;
	} out_word_t;

	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_MSG   = 3'd1;
	localparam logic [2:0] EV_PING  = 3'd2;
	localparam logic [2:0] EV_PONG  = 3'd3;
	localparam logic [2:0] EV_CLOSE = 3'd4;
	localparam logic [2:0] EV_ERR   = 3'd5;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_RSV        = 4'd1;
	localparam logic [3:0] ERR_MASKED     = 4'd2;
	localparam logic [3:0] ERR_RSVD_OP    = 4'd3;
	localparam logic [3:0] ERR_BAD_OP     = 4'd4;
	localparam logic [3:0] ERR_CTRL       = 4'd5;
	localparam logic [3:0] ERR_MINLEN     = 4'd6;
	localparam logic [3:0] ERR_LEN        = 4'd7;
	localparam logic [3:0] ERR_CONT       = 4'd8;
	localparam logic [3:0] ERR_INTERLEAVE = 4'd9;
	localparam logic [3:0] ERR_SIZE       = 4'd10;
	localparam logic [3:0] ERR_SHORT      = 4'd11;
	localparam logic [3:0] ERR_CODE       = 4'd12;

	localparam logic [3:0] OP_CONT   = 4'd0;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;
	localparam logic [3:0] OP_PING   = 4'd9;
	localparam logic [3:0] OP_PONG   = 4'd10;

	localparam logic [1:0] FRAG_NONE = 2'd0;

	localparam logic [15:0] CODE_NONE   = 16'd1005;
	localparam logic [15:0] CODE_1006   = 16'd1006;
	localparam logic [15:0] CODE_1013   = 16'd1013;
	localparam logic [15:0] CODE_1015   = 16'd1015;
	localparam logic [15:0] CODE_3000   = 16'd3000;
	localparam logic [15:0] CODE_5000   = 16'd5000;

	localparam logic [31:0] MAX_MSG_RESET = 32'd8388608;

endpackage

@@ hdl/wscfr_parse.sv @@
// Frame parser: header checks, fragment tracking and per-word result build.
module wscfr_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  wscfr_pkg::in_word_t word_s1,
	input  logic [31:0]         max_bytes,
	output logic                res_valid,
	output wscfr_pkg::out_word_t res
);

	typedef enum logic [1:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_PAY
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        fin_q, fin_n;
	logic        rsv_q, rsv_n;
	logic [63:0] acc_q, acc_n;
	logic [2:0]  ext_left_q, ext_left_n;
	logic        ext_long_q, ext_long_n;
	logic [31:0] rem_q, rem_n;
	logic [31:0] msg_q, msg_n;
	logic [1:0]  frag_q, frag_n;
	logic [6:0]  cnt_q, cnt_n;
	logic [15:0] ccode_q, ccode_n;
	logic        halted_q, halted_n;

	logic [7:0]  b;
	logic [6:0]  len7;
	logic [63:0] acc_sh;
	logic        hdr_fin, frm_fin;
	logic [63:0] hdr_len;
	logic [32:0] msg_sum;
	logic [3:0]  kind;
	logic [15:0] code;

	always_comb begin
		phase_n    = phase_q;
		opcode_n   = opcode_q;
		fin_n      = fin_q;
		rsv_n      = rsv_q;
		acc_n      = acc_q;
		ext_left_n = ext_left_q;
		ext_long_n = ext_long_q;
		rem_n      = rem_q;
		msg_n      = msg_q;
		frag_n     = frag_q;
		cnt_n      = cnt_q;
		ccode_n    = ccode_q;
		halted_n   = halted_q;
		res        = '0;
		hdr_fin    = 1'b0;
		frm_fin    = 1'b0;
		hdr_len    = '0;
		msg_sum    = '0;
		kind       = '0;
		code       = wscfr_pkg::CODE_NONE;
		b          = word_s1.rx_byte;
		len7       = b[6:0];
		acc_sh     = {acc_q[55:0], b};

		unique case (phase_q)
			PH_HDR0: begin
				opcode_n = b[3:0];
				fin_n    = b[7];
				rsv_n    = |b[6:4];
				phase_n  = PH_HDR1;
			end
			PH_HDR1: begin
				if (rsv_q) begin
					res.error_code = wscfr_pkg::ERR_RSV;
				end else if (b[7]) begin
					res.error_code = wscfr_pkg::ERR_MASKED;
				end else if (opcode_q > wscfr_pkg::OP_BINARY && opcode_q < wscfr_pkg::OP_CLOSE) begin
					res.error_code = wscfr_pkg::ERR_RSVD_OP;
				end else if (opcode_q > wscfr_pkg::OP_PONG) begin
					res.error_code = wscfr_pkg::ERR_BAD_OP;
				end else if (opcode_q >= wscfr_pkg::OP_CLOSE && (len7 > 7'd125 || !fin_q)) begin
					res.error_code = wscfr_pkg::ERR_CTRL;
				end else if (len7 == 7'd126) begin
					acc_n      = '0;
					ext_left_n = 3'd1;
					ext_long_n = 1'b0;
					phase_n    = PH_EXT;
				end else if (len7 == 7'd127) begin
					acc_n      = '0;
					ext_left_n = 3'd7;
					ext_long_n = 1'b1;
					phase_n    = PH_EXT;
				end else begin
					hdr_fin = 1'b1;
					hdr_len = {57'd0, len7};
				end
			end
			PH_EXT: begin
				acc_n = acc_sh;
				if (ext_left_q != 3'd0) begin
					ext_left_n = ext_left_q - 3'd1;
				end else if (!ext_long_q) begin
					if (acc_sh[15:0] < 16'd126) begin
						res.error_code = wscfr_pkg::ERR_MINLEN;
					end else begin
						hdr_fin = 1'b1;
						hdr_len = acc_sh;
					end
				end else begin
					if (acc_sh[63:16] == 48'd0 || acc_sh[63:62] != 2'd0) begin
						res.error_code = wscfr_pkg::ERR_LEN;
					end else begin
						hdr_fin = 1'b1;
						hdr_len = acc_sh;
					end
				end
			end
			PH_PAY: begin
				res.has_byte        = 1'b1;
				res.payload_byte    = b;
				res.byte_is_control = opcode_q >= wscfr_pkg::OP_CLOSE;
				if (res.byte_is_control) begin
					if (cnt_q == 7'd0) begin
						ccode_n = {b, 8'd0};
					end else if (cnt_q == 7'd1) begin
						ccode_n = {ccode_q[15:8], b};
					end
					if (cnt_q != 7'd127) begin
						cnt_n = cnt_q + 7'd1;
					end
				end else begin
					msg_n = msg_q + 32'd1;
				end
				if (rem_q != 32'd0) begin
					rem_n = rem_q - 32'd1;
				end
				frm_fin = rem_n == 32'd0;
			end
			default: begin
				phase_n = PH_HDR0;
			end
		endcase

		if (hdr_fin) begin
			msg_sum = {1'b0, msg_q} + {1'b0, hdr_len[31:0]};
			if (opcode_q < wscfr_pkg::OP_CLOSE && opcode_q == wscfr_pkg::OP_CONT &&
					frag_q == wscfr_pkg::FRAG_NONE) begin
				res.error_code = wscfr_pkg::ERR_CONT;
			end else if (opcode_q < wscfr_pkg::OP_CLOSE && opcode_q != wscfr_pkg::OP_CONT &&
					frag_q != wscfr_pkg::FRAG_NONE) begin
				res.error_code = wscfr_pkg::ERR_INTERLEAVE;
			end else if (opcode_q < wscfr_pkg::OP_CLOSE &&
					(hdr_len[63:32] != 32'd0 || msg_sum > {1'b0, max_bytes})) begin
				res.error_code = wscfr_pkg::ERR_SIZE;
			end else begin
				rem_n = hdr_len[31:0];
				cnt_n = '0;
				if (rem_n == 32'd0) begin
					frm_fin = 1'b1;
				end else begin
					phase_n = PH_PAY;
				end
			end
		end

		if (frm_fin) begin
			phase_n = PH_HDR0;
			if (opcode_q >= wscfr_pkg::OP_CLOSE) begin
				cnt_n = '0;
				if (opcode_q == wscfr_pkg::OP_PING) begin
					res.event_res = wscfr_pkg::EV_PING;
				end else if (opcode_q == wscfr_pkg::OP_PONG) begin
					res.event_res = wscfr_pkg::EV_PONG;
				end else if (cnt_q == 7'd1 && res.has_byte == 1'b0) begin
					res.error_code = wscfr_pkg::ERR_SHORT;
				end else begin
					if (res.has_byte) begin
						if (cnt_n == 7'd0 && cnt_q == 7'd0) begin
							code = wscfr_pkg::CODE_NONE;
						end
					end
					code = wscfr_pkg::CODE_NONE;
				end
			end
		end

		// Close frame completion needs the count as seen by the final byte.
		if (frm_fin && opcode_q == wscfr_pkg::OP_CLOSE) begin
			res.error_code = wscfr_pkg::ERR_NONE;
			code = wscfr_pkg::CODE_NONE;
			if (!hdr_fin && cnt_q == 7'd0) begin
				res.error_code = wscfr_pkg::ERR_SHORT;
			end else if (!hdr_fin) begin
				code = ccode_n;
				if (code == wscfr_pkg::CODE_1006 || code == wscfr_pkg::CODE_1015 ||
						(code > wscfr_pkg::CODE_1013 && code < wscfr_pkg::CODE_3000) ||
						code >= wscfr_pkg::CODE_5000) begin
					res.error_code = wscfr_pkg::ERR_CODE;
				end
			end
			if (res.error_code == wscfr_pkg::ERR_NONE) begin
				res.event_res  = wscfr_pkg::EV_CLOSE;
				res.close_code = code;
				res.echo_close = !word_s1.local_closing && code != wscfr_pkg::CODE_NONE;
				halted_n       = 1'b1;
			end
		end

		if (frm_fin && opcode_q < wscfr_pkg::OP_CLOSE) begin
			if (!fin_q) begin
				if (opcode_q != wscfr_pkg::OP_CONT) begin
					frag_n = opcode_q[1:0];
				end
			end else begin
				kind               = (opcode_q != wscfr_pkg::OP_CONT) ? opcode_q : {2'd0, frag_q};
				res.message_binary = kind == wscfr_pkg::OP_BINARY;
				res.event_res      = wscfr_pkg::EV_MSG;
				frag_n             = wscfr_pkg::FRAG_NONE;
				msg_n              = '0;
			end
		end

		if (res.error_code != wscfr_pkg::ERR_NONE) begin
			res.event_res = wscfr_pkg::EV_ERR;
			halted_n      = 1'b1;
		end

		res_valid = !halted_q && (res.has_byte || res.event_res != wscfr_pkg::EV_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			opcode_q   <= '0;
			fin_q      <= 1'b0;
			rsv_q      <= 1'b0;
			acc_q      <= '0;
			ext_left_q <= '0;
			ext_long_q <= 1'b0;
			rem_q      <= '0;
			msg_q      <= '0;
			frag_q     <= wscfr_pkg::FRAG_NONE;
			cnt_q      <= '0;
			ccode_q    <= '0;
			halted_q   <= 1'b0;
		end else if (step && !halted_q) begin
			phase_q    <= phase_n;
			opcode_q   <= opcode_n;
			fin_q      <= fin_n;
			rsv_q      <= rsv_n;
			acc_q      <= acc_n;
			ext_left_q <= ext_left_n;
			ext_long_q <= ext_long_n;
			rem_q      <= rem_n;
			msg_q      <= msg_n;
			frag_q     <= frag_n;
			cnt_q      <= cnt_n;
			ccode_q    <= ccode_n;
			halted_q   <= halted_n;
		end
	end

endmodule

@@ hdl/wscfr_outreg.sv @@
// Output register: holds one result word until the receiver takes it.
module wscfr_outreg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  wscfr_pkg::out_word_t load_word,
	output logic                 ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wscfr_pkg::out_word_t out_word
);

	logic                 valid_q;
	wscfr_pkg::out_word_t word_q;

	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			word_q <= load_word;
		end
	end

endmodule

@@ hdl/websocket_client_frame_receiver_unit.sv @@
// Top level of the websocket client frame receiver.
// Usage:
//   in_valid/in_stall/in_word carry one received stream byte per word plus
//   the local-closing flag. out_valid/out_stall/out_word carry at most one
//   result word per input word: a payload byte, a frame event, or both.
//   cfg_valid/cfg_ready/cfg_data write the maximum message size in bytes;
//   cfg_ready is always high. Write it only while the block is idle.
//   A word passes from the input register to the output register.
//   Throughput: one input word per cycle while out_stall is low; all header,
//   length and limit checks run combinationally between the input register
//   and the output register.
//   Reset clears all parse state and sets the limit to 8388608 bytes.
//   After an error or a received close the block keeps accepting words but
//   gives no more results until reset.
//   When the receiver stalls, the output register holds its word and the
//   input register fills; in_stall rises once both are occupied.
module websocket_client_frame_receiver_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wscfr_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wscfr_pkg::out_word_t out_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data
);

	logic                 valid_s1;
	wscfr_pkg::in_word_t  word_s1;
	logic [31:0]          max_bytes_q;
	logic                 ready;
	logic                 advance;
	logic                 res_valid;
	wscfr_pkg::out_word_t res;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && ready;
	assign in_stall  = valid_s1 && !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			max_bytes_q <= wscfr_pkg::MAX_MSG_RESET;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				max_bytes_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	wscfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.word_s1   (word_s1),
		.max_bytes (max_bytes_q),
		.res_valid (res_valid),
		.res       (res)
	);

	wscfr_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.load_word (res),
		.ready     (ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

@@ hdl/wscfr_checker.sv @@
// Port checker for the websocket client frame receiver, with its bind.
module wscfr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input wscfr_pkg::out_word_t out_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_word.event_res == wscfr_pkg::EV_ERR) ==
			(out_word.error_code != wscfr_pkg::ERR_NONE)))
		else $error("error code does not match error event");

	a_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.has_byte |-> out_word.event_res != wscfr_pkg::EV_NONE)
		else $error("result word without byte or event");

	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.echo_close |->
			out_word.event_res == wscfr_pkg::EV_CLOSE &&
			out_word.close_code != wscfr_pkg::CODE_NONE)
		else $error("close echo without a close code");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (out_word.event_res == wscfr_pkg::EV_ERR ||
			out_word.event_res == wscfr_pkg::EV_CLOSE) |=> !out_valid)
		else $error("result after halting event");

endmodule

bind websocket_client_frame_receiver_unit wscfr_checker u_wscfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

@@ verif/tb_websocket_client_frame_receiver_unit.sv @@
// Testbench for the websocket client frame receiver with a deframing predictor.
module tb_websocket_client_frame_receiver_unit;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 11;
	localparam int PHASES        = 6;
	localparam int PHASE_BYTES   = 290;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int TAIL_BYTES    = 20;
	localparam int DIR_ROWS      = 20;

	localparam logic [3:0]  OP_TEXT   = 4'd1;
	localparam logic [6:0]  CTRL_MAX  = 7'd125;
	localparam logic [6:0]  LEN_EXT16 = 7'd126;
	localparam logic [6:0]  LEN_EXT64 = 7'd127;
	localparam logic [63:0] EXT64_MIN = 64'd65536;
	localparam logic [63:0] HUGE_LEN  = 64'h0000_0100_0000_0000;

	typedef enum logic [2:0] {ST_HEAD0, ST_HEAD1, ST_LEN16, ST_LEN64, ST_BODY} parse_t;

	typedef struct packed {
		wscfr_pkg::in_word_t  word;
		logic                 typed;
		logic                 emits;
		wscfr_pkg::out_word_t res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	wscfr_pkg::in_word_t  in_word = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	wscfr_pkg::out_word_t out_word;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [31:0]          cfg_data = '0;

	websocket_client_frame_receiver_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// deframer state as the predictor sees it
	logic [31:0]          lim_bytes = wscfr_pkg::MAX_MSG_RESET;
	parse_t               st = ST_HEAD0;
	logic [3:0]           op = '0;
	logic                 fin = 1'b0;
	logic                 rsv = 1'b0;
	logic [63:0]          len_acc = '0;
	logic [3:0]           ext_left = '0;
	logic [31:0]          body_left = '0;
	logic [31:0]          msg_total = '0;
	logic [1:0]           frag = wscfr_pkg::FRAG_NONE;
	logic [6:0]           ctl_seen = '0;
	logic [15:0]          code_acc = '0;
	logic                 halted = 1'b0;
	wscfr_pkg::out_word_t pr;

	wscfr_pkg::out_word_t pending_results[$];
	dir_row_t             dir_tab [DIR_ROWS];
	int                   mismatches = 0;
	int                   results_seen = 0;
	int                   bytes_sent = 0;
	int                   phase_bytes = 0;
	int                   ev_seen [8];
	int                   snd_pct = 0;
	int                   rcv_pct = 0;
	logic                 hold_on = 1'b0;
	int                   ph_id = 0;
	int                   rcv_seen = 0;
	int                   rcv_cycle = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("tb_websocket_client_frame_receiver_unit: errors");
		$finish;
	end

	task automatic flag_error(input logic [3:0] code);
		pr.event_res = wscfr_pkg::EV_ERR;
		pr.error_code = code;
		halted = 1'b1;
	endtask

	task automatic end_of_frame(input logic lc);
		logic [6:0]  n;
		logic [15:0] code;
		logic [3:0]  kind;
		st = ST_HEAD0;
		if (op >= wscfr_pkg::OP_CLOSE) begin
			n = ctl_seen;
			code = wscfr_pkg::CODE_NONE;
			ctl_seen = '0;
			if (op == wscfr_pkg::OP_PING) begin
				pr.event_res = wscfr_pkg::EV_PING;
			end else if (op == wscfr_pkg::OP_PONG) begin
				pr.event_res = wscfr_pkg::EV_PONG;
			end else if (n == 7'd1) begin
				flag_error(wscfr_pkg::ERR_SHORT);
			end else begin
				if (n >= 7'd2) code = code_acc;
				if (n >= 7'd2 && (code == wscfr_pkg::CODE_1006 || code == wscfr_pkg::CODE_1015 ||
						(code > wscfr_pkg::CODE_1013 && code < wscfr_pkg::CODE_3000) ||
						code >= wscfr_pkg::CODE_5000)) begin
					flag_error(wscfr_pkg::ERR_CODE);
				end else begin
					pr.event_res = wscfr_pkg::EV_CLOSE;
					pr.close_code = code;
					pr.echo_close = !lc && code != wscfr_pkg::CODE_NONE;
					halted = 1'b1;
				end
			end
		end else if (!fin) begin
			if (op != wscfr_pkg::OP_CONT) frag = op[1:0];
		end else begin
			kind = (op != wscfr_pkg::OP_CONT) ? op : {2'b00, frag};
			pr.message_binary = (kind == wscfr_pkg::OP_BINARY);
			frag = wscfr_pkg::FRAG_NONE;
			msg_total = '0;
			pr.event_res = wscfr_pkg::EV_MSG;
		end
	endtask

	task automatic length_known(input logic [63:0] len, input logic lc);
		if (op < wscfr_pkg::OP_CLOSE && op == wscfr_pkg::OP_CONT &&
				frag == wscfr_pkg::FRAG_NONE) begin
			flag_error(wscfr_pkg::ERR_CONT);
		end else if (op < wscfr_pkg::OP_CLOSE && op != wscfr_pkg::OP_CONT &&
				frag != wscfr_pkg::FRAG_NONE) begin
			flag_error(wscfr_pkg::ERR_INTERLEAVE);
		end else if (op < wscfr_pkg::OP_CLOSE && (len > {32'b0, lim_bytes} ||
				{32'b0, msg_total} + len > {32'b0, lim_bytes})) begin
			flag_error(wscfr_pkg::ERR_SIZE);
		end else begin
			body_left = len[31:0];
			ctl_seen = '0;
			if (body_left == 0) end_of_frame(lc);
			else st = ST_BODY;
		end
	endtask

	task automatic deframe_byte(input wscfr_pkg::in_word_t w, output logic emit,
			output wscfr_pkg::out_word_t r);
		logic [7:0] b;
		logic       lc;
		b = w.rx_byte;
		lc = w.local_closing;
		pr = '0;
		emit = 1'b0;
		r = '0;
		if (!halted) begin
			case (st)
				ST_HEAD0: begin
					op = b[3:0];
					fin = b[7];
					rsv = |b[6:4];
					st = ST_HEAD1;
				end
				ST_HEAD1: begin
					if (rsv) flag_error(wscfr_pkg::ERR_RSV);
					else if (b[7]) flag_error(wscfr_pkg::ERR_MASKED);
					else if (op > wscfr_pkg::OP_BINARY && op < wscfr_pkg::OP_CLOSE)
						flag_error(wscfr_pkg::ERR_RSVD_OP);
					else if (op > wscfr_pkg::OP_PONG) flag_error(wscfr_pkg::ERR_BAD_OP);
					else if (op >= wscfr_pkg::OP_CLOSE && (b[6:0] > CTRL_MAX || !fin))
						flag_error(wscfr_pkg::ERR_CTRL);
					else if (b[6:0] == LEN_EXT16) begin
						len_acc = '0;
						ext_left = 4'd2;
						st = ST_LEN16;
					end else if (b[6:0] == LEN_EXT64) begin
						len_acc = '0;
						ext_left = 4'd8;
						st = ST_LEN64;
					end else begin
						length_known({57'b0, b[6:0]}, lc);
					end
				end
				ST_LEN16, ST_LEN64: begin
					len_acc = {len_acc[55:0], b};
					ext_left = ext_left - 4'd1;
					if (ext_left == 0) begin
						if (st == ST_LEN16 && len_acc < LEN_EXT16)
							flag_error(wscfr_pkg::ERR_MINLEN);
						else if (st == ST_LEN64 && (len_acc < EXT64_MIN || len_acc[63:62] != 0))
							flag_error(wscfr_pkg::ERR_LEN);
						else length_known(len_acc, lc);
					end
				end
				default: begin
					pr.has_byte = 1'b1;
					pr.payload_byte = b;
					pr.byte_is_control = (op >= wscfr_pkg::OP_CLOSE);
					if (op >= wscfr_pkg::OP_CLOSE) begin
						if (ctl_seen == 0) code_acc = {b, 8'h00};
						else if (ctl_seen == 1) code_acc[7:0] = b;
						if (ctl_seen < 7'd127) ctl_seen = ctl_seen + 7'd1;
					end else begin
						msg_total = msg_total + 32'd1;
					end
					if (body_left != 0) body_left = body_left - 32'd1;
					if (body_left == 0) end_of_frame(lc);
				end
			endcase
			emit = pr.has_byte || pr.event_res != wscfr_pkg::EV_NONE;
			r = pr;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input wscfr_pkg::out_word_t got);
		wscfr_pkg::out_word_t want;
		if (pending_results.size() == 0) begin
			$error("result with none pending: has_byte %0d event_res %0d", got.has_byte,
				got.event_res);
			mismatches++;
		end else begin
			want = pending_results.pop_front();
			check_field("has_byte", 64'(want.has_byte), 64'(got.has_byte));
			check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
			check_field("byte_is_control", 64'(want.byte_is_control),
				64'(got.byte_is_control));
			check_field("event_res", 64'(want.event_res), 64'(got.event_res));
			check_field("message_binary", 64'(want.message_binary), 64'(got.message_binary));
			check_field("close_code", 64'(want.close_code), 64'(got.close_code));
			check_field("echo_close", 64'(want.echo_close), 64'(got.echo_close));
			check_field("error_code", 64'(want.error_code), 64'(got.error_code));
			ev_seen[want.event_res]++;
			results_seen++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid === 1'b1 && !out_stall) check_result(out_word);
	end

	always @(posedge clk) begin
		if (ph_id != rcv_seen) begin
			rcv_seen <= ph_id;
			rcv_cycle <= 0;
		end else if (rcv_cycle < HOLD_CYCLES) begin
			rcv_cycle <= rcv_cycle + 1;
		end
		out_stall <= (hold_on && rcv_cycle < HOLD_CYCLES) ||
			(rcv_pct != 0 && $urandom_range(1, 100) <= rcv_pct);
	end

	task automatic offer(input wscfr_pkg::in_word_t w, input logic typed, input logic emits,
			input wscfr_pkg::out_word_t res);
		logic                 e;
		wscfr_pkg::out_word_t r;
		while (snd_pct != 0 && $urandom_range(1, 100) <= snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		deframe_byte(w, e, r);
		if (typed) begin
			e = emits;
			r = res;
		end
		if (e) pending_results.push_back(r);
		bytes_sent++;
		phase_bytes++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		wscfr_pkg::in_word_t w;
		w.rx_byte = b;
		w.local_closing = 1'($urandom_range(0, 1));
		offer(w, 1'b0, 1'b0, '0);
	endtask

	task automatic send_ext(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) send_byte(v[8 * i +: 8]);
	endtask

	task automatic send_header(input logic f, input logic [3:0] opc, input logic [63:0] len);
		send_byte({f, 3'b000, opc});
		if (len < LEN_EXT16) begin
			send_byte({1'b0, len[6:0]});
		end else if (len < EXT64_MIN) begin
			send_byte({1'b0, LEN_EXT16});
			send_ext(len, 2);
		end else begin
			send_byte({1'b0, LEN_EXT64});
			send_ext(len, 8);
		end
	endtask

	task automatic send_frame(input logic f, input logic [3:0] opc, input logic [63:0] len);
		send_header(f, opc, len);
		for (longint i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_close(input logic [15:0] code, input int extra);
		send_header(1'b1, wscfr_pkg::OP_CLOSE, 64'(2 + extra));
		send_byte(code[15:8]);
		send_byte(code[7:0]);
		repeat (extra) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic random_frame();
		logic [32:0] room;
		logic [63:0] len;
		logic [3:0]  opc;
		logic        f;
		room = {1'b0, lim_bytes} - {1'b0, msg_total};
		if ($urandom_range(0, 9) < 2) begin
			opc = $urandom_range(0, 1) ? wscfr_pkg::OP_PING : wscfr_pkg::OP_PONG;
			len = ($urandom_range(0, 9) == 0) ? 64'(CTRL_MAX) : 64'($urandom_range(0, 6));
			send_frame(1'b1, opc, len);
		end else begin
			len = ($urandom_range(0, 15) == 0) ? 64'($urandom_range(LEN_EXT16, 200))
				: 64'($urandom_range(0, 10));
			if (len > room) len = 64'($urandom_range(0, room[31:0]));
			if ($urandom_range(0, 7) == 0 && room <= 200) len = 64'(room);
			if (frag == wscfr_pkg::FRAG_NONE) begin
				opc = $urandom_range(0, 1) ? OP_TEXT : wscfr_pkg::OP_BINARY;
				f = ($urandom_range(0, 9) < 7);
			end else begin
				opc = wscfr_pkg::OP_CONT;
				f = 1'($urandom_range(0, 1));
			end
			send_frame(f, opc, len);
		end
	endtask

	// finish the stream with a frame that ends in a close or an error, after a setup frame for some errors
	task automatic end_stream();
		logic [3:0]  target;
		logic [3:0]  opc;
		logic [15:0] code;
		logic [32:0] room;
		target = 4'($urandom_range(wscfr_pkg::ERR_NONE, wscfr_pkg::ERR_CODE));
		case ($urandom_range(0, 5))
			0: code = wscfr_pkg::CODE_1013 - 16'($urandom_range(0, 13));
			1: code = wscfr_pkg::CODE_1013 + 16'($urandom_range(1, 3));
			2: code = 16'($urandom_range(wscfr_pkg::CODE_1015, wscfr_pkg::CODE_3000));
			3: code = 16'($urandom_range(wscfr_pkg::CODE_3000 - 1, wscfr_pkg::CODE_5000));
			4: code = 16'($urandom_range(wscfr_pkg::CODE_5000, 16'hFFFF));
			default: code = 16'($urandom_range(0, 16'hFFFF));
		endcase
		case (target)
			wscfr_pkg::ERR_NONE: begin
				if ($urandom_range(0, 1)) send_frame(1'b1, wscfr_pkg::OP_CLOSE, 64'd0);
				else send_close(wscfr_pkg::CODE_1013 - 16'($urandom_range(0, 13)),
					$urandom_range(0, 3));
			end
			wscfr_pkg::ERR_RSV: begin
				opc = $urandom_range(0, 1) ? OP_TEXT : wscfr_pkg::OP_PING;
				send_byte({1'b1, 3'($urandom_range(1, 7)), opc});
				send_byte(8'($urandom_range(0, 255)));
			end
			wscfr_pkg::ERR_MASKED: begin
				send_byte({1'b1, 3'b000, wscfr_pkg::OP_BINARY});
				send_byte(8'h80 | 8'($urandom_range(0, 127)));
			end
			wscfr_pkg::ERR_RSVD_OP, wscfr_pkg::ERR_BAD_OP: begin
				opc = (target == wscfr_pkg::ERR_RSVD_OP)
					? 4'($urandom_range(wscfr_pkg::OP_BINARY + 1, wscfr_pkg::OP_CLOSE - 1))
					: 4'($urandom_range(wscfr_pkg::OP_PONG + 1, 15));
				send_byte({1'b1, 3'b000, opc});
				send_byte(8'($urandom_range(0, CTRL_MAX)));
			end
			wscfr_pkg::ERR_CTRL: begin
				opc = wscfr_pkg::OP_CLOSE + 4'($urandom_range(0, 2));
				if ($urandom_range(0, 1)) begin
					send_byte({1'b0, 3'b000, opc});
					send_byte(8'($urandom_range(0, CTRL_MAX)));
				end else begin
					send_byte({1'b1, 3'b000, opc});
					send_byte({1'b0, $urandom_range(0, 1) ? LEN_EXT16 : LEN_EXT64});
				end
			end
			wscfr_pkg::ERR_MINLEN: begin
				send_byte({1'b1, 3'b000, OP_TEXT});
				send_byte({1'b0, LEN_EXT16});
				send_ext(64'($urandom_range(0, LEN_EXT16 - 1)), 2);
			end
			wscfr_pkg::ERR_LEN: begin
				send_byte({1'b1, 3'b000, wscfr_pkg::OP_BINARY});
				send_byte({1'b0, LEN_EXT64});
				if ($urandom_range(0, 1)) send_ext(64'($urandom_range(0, EXT64_MIN - 1)), 8);
				else send_ext({2'($urandom_range(1, 3)), 30'($urandom), 32'($urandom)}, 8);
			end
			wscfr_pkg::ERR_CONT: begin
				if (frag != wscfr_pkg::FRAG_NONE) send_frame(1'b1, wscfr_pkg::OP_CONT, 64'd0);
				send_header(1'b1, wscfr_pkg::OP_CONT, 64'($urandom_range(0, 5)));
			end
			wscfr_pkg::ERR_INTERLEAVE: begin
				if (frag == wscfr_pkg::FRAG_NONE) send_frame(1'b0, OP_TEXT, 64'd0);
				send_header(1'b1, wscfr_pkg::OP_BINARY, 64'($urandom_range(0, 5)));
			end
			wscfr_pkg::ERR_SIZE: begin
				opc = (frag == wscfr_pkg::FRAG_NONE) ? wscfr_pkg::OP_BINARY : wscfr_pkg::OP_CONT;
				room = {1'b0, lim_bytes} - {1'b0, msg_total};
				if ($urandom_range(0, 1) && room < 1000) send_header(1'b1, opc, 64'(room) + 1);
				else send_header(1'b1, opc, HUGE_LEN);
			end
			wscfr_pkg::ERR_SHORT: begin
				send_header(1'b1, wscfr_pkg::OP_CLOSE, 64'd1);
				send_byte(8'($urandom_range(0, 255)));
			end
			default: send_close(code, $urandom_range(0, 3));
		endcase
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [31:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		lim_bytes = v;
	endtask

	function automatic wscfr_pkg::out_word_t mk_res(input logic has, input logic [7:0] pb,
			input logic ctl, input logic [2:0] ev, input logic bin);
		wscfr_pkg::out_word_t r;
		r = '0;
		r.has_byte = has;
		r.payload_byte = pb;
		r.byte_is_control = ctl;
		r.event_res = ev;
		r.message_binary = bin;
		return r;
	endfunction

	function automatic dir_row_t typed_row(input logic [7:0] b, input logic lc,
			input logic emits, input wscfr_pkg::out_word_t res);
		dir_row_t row;
		row.word.rx_byte = b;
		row.word.local_closing = lc;
		row.typed = 1'b1;
		row.emits = emits;
		row.res = res;
		return row;
	endfunction

	function automatic dir_row_t pred_row(input logic [7:0] b, input logic lc);
		dir_row_t row;
		row = '0;
		row.word.rx_byte = b;
		row.word.local_closing = lc;
		return row;
	endfunction

	initial begin
		wscfr_pkg::out_word_t none;
		logic [31:0]          lim;
		none = '0;
		foreach (ev_seen[i]) ev_seen[i] = 0;

		dir_tab[0]  = typed_row(8'h81, 1'b0, 1'b0, none);
		dir_tab[1]  = typed_row(8'h00, 1'b1, 1'b1,
			mk_res(1'b0, 8'h00, 1'b0, wscfr_pkg::EV_MSG, 1'b0));
		dir_tab[2]  = typed_row(8'h82, 1'b1, 1'b0, none);
		dir_tab[3]  = typed_row(8'h01, 1'b0, 1'b0, none);
		dir_tab[4]  = typed_row(8'hFF, 1'b1, 1'b1,
			mk_res(1'b1, 8'hFF, 1'b0, wscfr_pkg::EV_MSG, 1'b1));
		dir_tab[5]  = typed_row(8'h89, 1'b0, 1'b0, none);
		dir_tab[6]  = typed_row(8'h02, 1'b0, 1'b0, none);
		dir_tab[7]  = typed_row(8'h00, 1'b1, 1'b1,
			mk_res(1'b1, 8'h00, 1'b1, wscfr_pkg::EV_NONE, 1'b0));
		dir_tab[8]  = typed_row(8'h80, 1'b0, 1'b1,
			mk_res(1'b1, 8'h80, 1'b1, wscfr_pkg::EV_PING, 1'b0));
		dir_tab[9]  = typed_row(8'h8A, 1'b1, 1'b0, none);
		dir_tab[10] = typed_row(8'h00, 1'b0, 1'b1,
			mk_res(1'b0, 8'h00, 1'b0, wscfr_pkg::EV_PONG, 1'b0));
		dir_tab[11] = pred_row(8'h01, 1'b1);
		dir_tab[12] = pred_row(8'h01, 1'b0);
		dir_tab[13] = pred_row(8'h41, 1'b1);
		dir_tab[14] = pred_row(8'h8A, 1'b0);
		dir_tab[15] = pred_row(8'h01, 1'b1);
		dir_tab[16] = pred_row(8'h3C, 1'b0);
		dir_tab[17] = pred_row(8'h80, 1'b1);
		dir_tab[18] = pred_row(8'h01, 1'b0);
		dir_tab[19] = pred_row(8'h7E, 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			offer(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].emits, dir_tab[i].res);

		for (int p = 1; p <= PHASES; p++) begin
			case (p)
				1: lim = 32'hFFFF_FFFF;
				2: lim = 32'd0;
				3: lim = 32'd1;
				4: lim = 32'd300;
				5: lim = 32'd5000;
				default: lim = $urandom_range(150, 400);
			endcase
			if (frag != wscfr_pkg::FRAG_NONE) send_frame(1'b1, wscfr_pkg::OP_CONT, 64'd0);
			set_limit(lim);
			snd_pct = (p == 2) ? 82 : (p == 4 || p == 6) ? 37 : 0;
			rcv_pct <= (p == 3) ? 82 : (p == 4 || p == 6) ? 37 : 0;
			hold_on <= (p == 1);
			ph_id <= p;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) random_frame();
		end

		end_stream();
		repeat (TAIL_BYTES) send_byte(8'($urandom_range(0, 255)));
		in_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++) @(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end

		$display("Run summary: %0d stream bytes over %0d limit settings, %0d results checked",
			bytes_sent, PHASES + 1, results_seen);
		$display("  events: %0d messages, %0d pings, %0d pongs, %0d closes, %0d errors",
			ev_seen[wscfr_pkg::EV_MSG], ev_seen[wscfr_pkg::EV_PING],
			ev_seen[wscfr_pkg::EV_PONG], ev_seen[wscfr_pkg::EV_CLOSE],
			ev_seen[wscfr_pkg::EV_ERR]);
		if (mismatches == 0) begin
			$display("tb_websocket_client_frame_receiver_unit: clean");
		end else begin
			$display("tb_websocket_client_frame_receiver_unit: errors");
		end
		$finish;
	end

endmodule
